### rtl/double_hash_key_value_table_assert.svh
// ----------------------------------------------------------------------------
// double_hash_key_value_table_assert.svh
// assertion macros shared by the key/value table rtl
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH
`define DOUBLE_HASH_KEY_VALUE_TABLE_ASSERT_SVH

// condition in the same cycle implies consequence
`define DHKV_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dhkv assertion failed");

// condition implies consequence in the next cycle
`define DHKV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dhkv assertion failed");

`endif

### rtl/dhkv_pkg.sv
// ----------------------------------------------------------------------------
// dhkv_pkg
// shared constants, op codes and record types of the key/value table
// ----------------------------------------------------------------------------
package dhkv_pkg;

  // table geometry
  localparam int TABLE_SLOTS = 1024;
  localparam int STORE_DEPTH = 1024;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int ENTRY_W     = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ENTRY_W + 1;

  // field widths
  localparam int OP_W    = 2;
  localparam int KTYPE_W = 3;
  localparam int VTYPE_W = 3;
  localparam int WORD_W  = 64;
  localparam int HASH_W  = 32;

  // op codes
  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // hash unit result
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] walk;
  } hash_res_t;

  // one slot of the probe table
  typedef struct packed {
    logic               used;
    logic [KTYPE_W-1:0] key_type;
    logic [WORD_W-1:0]  key_word;
    logic [ENTRY_W-1:0] entry;
  } slot_rec_t;

  // slot table write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_rec_t         data;
  } slot_wr_t;

  // one entry of the value store
  typedef struct packed {
    logic [VTYPE_W-1:0] vtype;
    logic [WORD_W-1:0]  vword;
  } value_rec_t;

  // value store write request
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] addr;
    value_rec_t         data;
  } value_wr_t;

endpackage

### rtl/dhkv_hash.sv
// ----------------------------------------------------------------------------
// dhkv_hash
// iterative shift/add hash unit, one shuffle step per cycle
// ----------------------------------------------------------------------------
module dhkv_hash
  import dhkv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] key_lo,
  output hash_res_t         res
);

  localparam int STEP_W = 4;

  // step codes of the shared unit
  localparam logic [STEP_W-1:0] STEP_MIX_IN  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ADD16   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_XOR3    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ADD5    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_XOR2    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ADD15   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_XOR10   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MIX_OUT = 4'd7;
  localparam logic [STEP_W-1:0] STEP_WALK    = 4'd8;

  logic [HASH_W-1:0] h_r, h_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic [STEP_W-1:0] sel;
  logic [HASH_W-1:0] opnd;
  logic [HASH_W-1:0] alu;

  function automatic logic [HASH_W-1:0] mix(input logic [HASH_W-1:0] a);
    mix = a + (a >> 6) + (a >> 19);
  endfunction

  // shared shift/add/xor unit
  assign sel  = start ? STEP_MIX_IN : step_r;
  assign opnd = start ? key_lo : h_r;

  always_comb begin
    case (sel)
      STEP_MIX_IN:  alu = mix(opnd);
      STEP_ADD16:   alu = opnd + (opnd << 16);
      STEP_XOR3:    alu = opnd ^ (opnd << 3);
      STEP_ADD5:    alu = opnd + (opnd >> 5);
      STEP_XOR2:    alu = opnd ^ (opnd << 2);
      STEP_ADD15:   alu = opnd + (opnd >> 15);
      STEP_XOR10:   alu = opnd ^ (opnd << 10);
      STEP_MIX_OUT: alu = mix(opnd);
      STEP_WALK:    alu = mix(opnd) | {{(HASH_W-1){1'b0}}, 1'b1};
      default:      alu = opnd;
    endcase
  end

  // step sequencer
  always_comb begin
    h_nxt    = h_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    if (start) begin
      h_nxt    = alu;
      step_nxt = STEP_ADD16;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      step_nxt = step_r + 4'd1;
      if (step_r == STEP_WALK) begin
        run_nxt = 1'b0;
      end else begin
        h_nxt = alu;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_MIX_IN;
      run_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  // head slot and odd walk, valid in the last step
  assign res.valid = run_r && (step_r == STEP_WALK);
  assign res.head  = h_r[SLOT_W-1:0];
  assign res.walk  = alu[SLOT_W-1:0];

endmodule

### rtl/dhkv_slots.sv
// ----------------------------------------------------------------------------
// dhkv_slots
// probe slot table with registered read and a clearing sweep after reset
// ----------------------------------------------------------------------------
module dhkv_slots
  import dhkv_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_rec_t         rd_data,
  input  slot_wr_t          wr,
  output logic              clearing
);

  slot_rec_t         mem [TABLE_SLOTS];
  slot_rec_t         rd_data_r;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clearing_r, clearing_nxt;

  // clearing sweep, one slot a cycle
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  // write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

endmodule

### rtl/dhkv_values.sv
// ----------------------------------------------------------------------------
// dhkv_values
// dense value store indexed by entry number
// ----------------------------------------------------------------------------
module dhkv_values
  import dhkv_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ENTRY_W-1:0] rd_addr,
  output value_rec_t         rd_data,
  input  value_wr_t          wr
);

  value_rec_t mem [STORE_DEPTH];
  value_rec_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/double_hash_key_value_table.sv
// ----------------------------------------------------------------------------
// double_hash_key_value_table
// open-addressing key/value table with double hashing
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on the out_ ports for exactly one cycle with out_valid high, and
// the receiver cannot hold it off. After reset the slot table is swept
// clear, one slot a cycle, and busy stays high until the sweep ends. Each
// item then passes through the iterative hash unit and, per probed slot,
// a slot table read and then a compare; a lookup that hits adds a value
// store read before the result strobe, and the next item can be taken in
// the cycle after the strobe. An unused op code gives its all-zero result
// in the cycle after it is taken.
module double_hash_key_value_table
  import dhkv_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [KTYPE_W-1:0] in_key_type,
  input  logic [WORD_W-1:0]  in_key_word,
  input  logic [VTYPE_W-1:0] in_value_type,
  input  logic [WORD_W-1:0]  in_value_word,
  output logic               out_valid,
  output logic               out_hit,
  output logic [VTYPE_W-1:0] out_result_type,
  output logic [WORD_W-1:0]  out_result_word,
  output logic [ENTRY_W-1:0] out_entry_index,
  output logic               out_status
);

  `include "double_hash_key_value_table_assert.svh"

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HASH  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_VLOAD = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] entry_count_r, entry_count_nxt;

  // captured item
  logic [OP_W-1:0]    op_r;
  logic [KTYPE_W-1:0] key_type_r;
  logic [WORD_W-1:0]  key_word_r;
  logic [VTYPE_W-1:0] value_type_r;
  logic [WORD_W-1:0]  value_word_r;

  // probe position
  logic [SLOT_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [SLOT_W-1:0]  walk_r, walk_nxt;
  logic [SLOT_W-1:0]  pos_step;

  // result registers
  logic               res_hit_r, res_hit_nxt;
  logic [VTYPE_W-1:0] res_type_r, res_type_nxt;
  logic [WORD_W-1:0]  res_word_r, res_word_nxt;
  logic [ENTRY_W-1:0] res_index_r, res_index_nxt;
  logic               res_status_r, res_status_nxt;

  logic               accept;
  logic               clearing;
  hash_res_t          hres;
  slot_rec_t          slot_rd;
  logic               slot_rd_en;
  slot_wr_t           slot_wr;
  value_rec_t         val_rd;
  logic               val_rd_en;
  logic [ENTRY_W-1:0] val_rd_addr;
  value_wr_t          val_wr;
  logic               key_match;
  logic               store_full;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE) || clearing;

  // shared hash unit
  dhkv_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept && (in_op != OP_NONE)),
    .key_lo (in_key_word[HASH_W-1:0]),
    .res    (hres)
  );

  // slot table
  dhkv_slots u_slots (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (slot_rd_en),
    .rd_addr  (pos_r),
    .rd_data  (slot_rd),
    .wr       (slot_wr),
    .clearing (clearing)
  );

  // value store
  dhkv_values u_values (
    .clk     (clk),
    .rd_en   (val_rd_en),
    .rd_addr (val_rd_addr),
    .rd_data (val_rd),
    .wr      (val_wr)
  );

  assign key_match  = slot_rd.used && (slot_rd.key_type == key_type_r) &&
                      (slot_rd.key_word == key_word_r);
  assign store_full = entry_count_r >= COUNT_W'(STORE_DEPTH);
  assign pos_step   = pos_r + walk_r;

  // sequencer and result build-up
  always_comb begin
    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    pos_nxt         = pos_r;
    head_nxt        = head_r;
    walk_nxt        = walk_r;
    res_hit_nxt     = res_hit_r;
    res_type_nxt    = res_type_r;
    res_word_nxt    = res_word_r;
    res_index_nxt   = res_index_r;
    res_status_nxt  = res_status_r;
    slot_rd_en      = 1'b0;
    slot_wr         = '0;
    val_rd_en       = 1'b0;
    val_rd_addr     = slot_rd.entry;
    val_wr          = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_hit_nxt    = 1'b0;
          res_type_nxt   = '0;
          res_word_nxt   = '0;
          res_index_nxt  = '0;
          res_status_nxt = 1'b0;
          state_nxt      = (in_op == OP_NONE) ? ST_DONE : ST_HASH;
        end
      end
      ST_HASH: begin
        if (hres.valid) begin
          pos_nxt   = hres.head;
          head_nxt  = hres.head;
          walk_nxt  = hres.walk;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        slot_rd_en = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        if (key_match) begin
          // key present
          res_hit_nxt   = 1'b1;
          res_index_nxt = slot_rd.entry;
          state_nxt     = ST_DONE;
          if (op_r == OP_PUT) begin
            val_wr.en         = 1'b1;
            val_wr.addr       = slot_rd.entry;
            val_wr.data.vtype = value_type_r;
            val_wr.data.vword = value_word_r;
          end else if (op_r == OP_LOOKUP) begin
            val_rd_en = 1'b1;
            state_nxt = ST_VLOAD;
          end
        end else if (!slot_rd.used) begin
          // empty slot: insert unless lookup or the store is full
          state_nxt = ST_DONE;
          if (op_r != OP_LOOKUP) begin
            if (store_full) begin
              res_status_nxt = 1'b1;
            end else begin
              val_wr.en           = 1'b1;
              val_wr.addr         = entry_count_r[ENTRY_W-1:0];
              val_wr.data.vtype   = (op_r == OP_PUT) ? value_type_r : '0;
              val_wr.data.vword   = (op_r == OP_PUT) ? value_word_r : '0;
              slot_wr.en          = 1'b1;
              slot_wr.addr        = pos_r;
              slot_wr.data.used     = 1'b1;
              slot_wr.data.key_type = key_type_r;
              slot_wr.data.key_word = key_word_r;
              slot_wr.data.entry    = entry_count_r[ENTRY_W-1:0];
              res_index_nxt       = entry_count_r[ENTRY_W-1:0];
              entry_count_nxt     = entry_count_r + 1'b1;
            end
          end
        end else begin
          // occupied by another key: step on, full on wrap
          pos_nxt = pos_step;
          if (pos_step == head_r) begin
            res_status_nxt = 1'b1;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_VLOAD: begin
        res_type_nxt = val_rd.vtype;
        res_word_nxt = val_rd.vword;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r         <= in_op;
      key_type_r   <= in_key_type;
      key_word_r   <= in_key_word;
      value_type_r <= in_value_type;
      value_word_r <= in_value_word;
    end
    pos_r        <= pos_nxt;
    head_r       <= head_nxt;
    walk_r       <= walk_nxt;
    res_hit_r    <= res_hit_nxt;
    res_type_r   <= res_type_nxt;
    res_word_r   <= res_word_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
  end

  // result ports
  assign out_valid       = (state_r == ST_DONE);
  assign out_hit         = res_hit_r;
  assign out_result_type = res_type_r;
  assign out_result_word = res_word_r;
  assign out_entry_index = res_index_r;
  assign out_status      = res_status_r;

  // checks
  `DHKV_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `DHKV_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `DHKV_ASSERT_SAME(a_full_clean, out_valid && out_status,
                    !out_hit && (out_entry_index == '0) && (out_result_word == '0))
  `DHKV_ASSERT_SAME(a_count_bound, 1'b1, entry_count_r <= COUNT_W'(STORE_DEPTH))
  `DHKV_ASSERT_SAME(a_no_item_while_clearing, clearing, state_r == ST_IDLE)

endmodule

### bench/tb_double_hash_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_hash_key_value_table
// self-checking bench for the double-hashed key/value table
// ----------------------------------------------------------------------------
// Sends put, lookup, take and unused-op items through the start/busy
// handshake. Each item is also run through an untimed copy of the table:
// the hash, the probe walk, the slot table and the value store. Every
// result strobe is compared with the oldest predicted answer. The run
// covers corner items, random mixes with and without sender gaps, and a
// filled table on which the probe walk comes back to its start slot.
// ----------------------------------------------------------------------------
module tb_double_hash_key_value_table;
  import dhkv_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int QUIET_LIMIT = 12000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 100;

  localparam bit [VTYPE_W-1:0] VAL_NIL = '0;

  // key kinds, the last two have no meaning but are legal
  typedef enum bit [KTYPE_W-1:0] {
    KIND_INT, KIND_NUM, KIND_TAB, KIND_CLS, KIND_SYS, KIND_BID, KIND_SPARE6, KIND_SPARE7
  } key_kind_t;

  typedef struct {
    bit [KTYPE_W-1:0] ktype;
    bit [WORD_W-1:0]  kword;
  } table_key_t;

  typedef struct {
    bit               hit;
    bit [VTYPE_W-1:0] rtype;
    bit [WORD_W-1:0]  rword;
    bit [ENTRY_W-1:0] index;
    bit               full;
  } table_answer_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic [OP_W-1:0]    in_op           = OP_NONE;
  logic [KTYPE_W-1:0] in_key_type     = '0;
  logic [WORD_W-1:0]  in_key_word     = '0;
  logic [VTYPE_W-1:0] in_value_type   = '0;
  logic [WORD_W-1:0]  in_value_word   = '0;
  logic               out_valid;
  logic               out_hit;
  logic [VTYPE_W-1:0] out_result_type;
  logic [WORD_W-1:0]  out_result_word;
  logic [ENTRY_W-1:0] out_entry_index;
  logic               out_status;

  // untimed copy of the table
  bit               tbl_used  [TABLE_SLOTS];
  bit [KTYPE_W-1:0] tbl_ktype [TABLE_SLOTS];
  bit [WORD_W-1:0]  tbl_kword [TABLE_SLOTS];
  bit [ENTRY_W-1:0] tbl_entry [TABLE_SLOTS];
  bit [VTYPE_W-1:0] tbl_vtype [STORE_DEPTH];
  bit [WORD_W-1:0]  tbl_vword [STORE_DEPTH];
  int unsigned      tbl_count = 0;

  table_key_t    key_pool[$];
  table_answer_t pending_answers[$];
  int            gap_pct      = 0;
  int            fail_count   = 0;
  int            quiet_cycles = 0;

  double_hash_key_value_table i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_key_type     (in_key_type),
    .in_key_word     (in_key_word),
    .in_value_type   (in_value_type),
    .in_value_word   (in_value_word),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_result_type (out_result_type),
    .out_result_word (out_result_word),
    .out_entry_index (out_entry_index),
    .out_status      (out_status)
  );

  always #CLK_HALF clk = ~clk;

  // shift/add shuffle used at both ends of the hash and for the step
  function automatic bit [HASH_W-1:0] shuffle32(bit [HASH_W-1:0] h);
    return h + (h >> 6) + (h >> 19);
  endfunction

  function automatic bit [HASH_W-1:0] key_hash32(bit [WORD_W-1:0] word);
    bit [HASH_W-1:0] h;
    h = shuffle32(word[HASH_W-1:0]);
    h += h << 16;
    h ^= h << 3;
    h += h >> 5;
    h ^= h << 2;
    h += h >> 15;
    h ^= h << 10;
    return shuffle32(h);
  endfunction

  // probe walk, returns 0 when it comes back to its start slot
  function automatic bit find_slot(bit [KTYPE_W-1:0] ktype, bit [WORD_W-1:0] kword,
                                   output bit [SLOT_W-1:0] slot);
    bit [HASH_W-1:0] h;
    bit [HASH_W-1:0] step_word;
    bit [SLOT_W-1:0] head;
    bit [SLOT_W-1:0] stride;
    bit [SLOT_W-1:0] pos;
    h         = key_hash32(kword);
    step_word = shuffle32(h) | 1;
    head      = h[SLOT_W-1:0];
    stride    = step_word[SLOT_W-1:0];
    pos       = head;
    slot      = '0;
    do begin
      if (!tbl_used[pos] || (tbl_ktype[pos] == ktype && tbl_kword[pos] == kword)) begin
        slot = pos;
        return 1'b1;
      end
      pos = pos + stride;
    end while (pos != head);
    return 1'b0;
  endfunction

  // apply one item to the table copy and give the answer it must produce
  function automatic table_answer_t table_apply(bit [OP_W-1:0] op, table_key_t key,
                                                bit [VTYPE_W-1:0] vtype,
                                                bit [WORD_W-1:0] vword);
    table_answer_t ans;
    bit [SLOT_W-1:0]  slot;
    bit [ENTRY_W-1:0] idx;
    ans = '{default: 0};
    if (op == OP_NONE)
      return ans;
    if (!find_slot(key.ktype, key.kword, slot)) begin
      ans.full = 1'b1;
      return ans;
    end
    // key already present
    if (tbl_used[slot]) begin
      idx       = tbl_entry[slot];
      ans.hit   = 1'b1;
      ans.index = idx;
      if (op == OP_PUT) begin
        tbl_vtype[idx] = vtype;
        tbl_vword[idx] = vword;
      end else if (op == OP_LOOKUP) begin
        ans.rtype = tbl_vtype[idx];
        ans.rword = tbl_vword[idx];
      end
      return ans;
    end
    if (op == OP_LOOKUP)
      return ans;
    // value store out of entries
    if (tbl_count >= STORE_DEPTH) begin
      ans.full = 1'b1;
      return ans;
    end
    // new entry, take stores nil
    idx            = tbl_count[ENTRY_W-1:0];
    tbl_count      = tbl_count + 1;
    tbl_vtype[idx] = (op == OP_PUT) ? vtype : VAL_NIL;
    tbl_vword[idx] = (op == OP_PUT) ? vword : '0;
    tbl_used[slot]  = 1'b1;
    tbl_ktype[slot] = key.ktype;
    tbl_kword[slot] = key.kword;
    tbl_entry[slot] = idx;
    ans.index       = idx;
    key_pool.push_back(key);
    return ans;
  endfunction

  function automatic table_key_t key_of(key_kind_t kind, bit [WORD_W-1:0] word);
    table_key_t k;
    k.ktype = kind;
    k.kword = word;
    return k;
  endfunction

  // mostly known keys, keys sharing a hash and fresh keys
  function automatic table_key_t pick_key();
    table_key_t  k;
    table_key_t  known;
    int unsigned roll;
    roll    = $urandom_range(99);
    k.ktype = KTYPE_W'($urandom_range(7));
    k.kword = {$urandom, $urandom};
    if (key_pool.size() != 0) begin
      known = key_pool[$urandom_range(key_pool.size() - 1)];
      if (roll < 55)
        k = known;
      else if (roll < 70)
        k.kword[HASH_W-1:0] = known.kword[HASH_W-1:0];
      else if (roll < 78)
        k.kword = known.kword;
    end
    return k;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                 logic [WORD_W-1:0] want);
    if (fail_count < PRINT_CAP)
      $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // present one item and hold it until the block takes it
  task automatic send_item(bit [OP_W-1:0] op, table_key_t key, bit [VTYPE_W-1:0] vtype,
                           bit [WORD_W-1:0] vword);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_key_type   <= key.ktype;
    in_key_word   <= key.kword;
    in_value_type <= vtype;
    in_value_word <= vword;
    do @(posedge clk); while (busy !== 1'b0);
    pending_answers.push_back(table_apply(op, key, vtype, vword));
  endtask

  task automatic send_random_item();
    bit [OP_W-1:0] op;
    int unsigned   roll;
    roll = $urandom_range(99);
    if (roll < 5)
      op = OP_NONE;
    else if (roll < 40)
      op = OP_PUT;
    else if (roll < 70)
      op = OP_LOOKUP;
    else
      op = OP_TAKE;
    send_item(op, pick_key(), VTYPE_W'($urandom_range(7)), {$urandom, $urandom});
  endtask

  // hold the sender until every pending answer has been checked
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // field extremes, every op, nil values, shared hashes, unused op and kinds
  task automatic test_directed_corners();
    gap_pct = 0;
    send_item(OP_PUT,    key_of(KIND_INT, '0), '1, '1);
    send_item(OP_LOOKUP, key_of(KIND_INT, '0), VAL_NIL, '0);
    send_item(OP_PUT,    key_of(KIND_SPARE7, '1), VAL_NIL, '0);
    send_item(OP_LOOKUP, key_of(KIND_SPARE7, '1), '1, '1);
    send_item(OP_TAKE,   key_of(KIND_SPARE7, '1), '1, '1);
    send_item(OP_TAKE,   key_of(KIND_SPARE6, 64'h8000_0000_0000_0001), '1, '1);
    send_item(OP_LOOKUP, key_of(KIND_SPARE6, 64'h8000_0000_0000_0001), VAL_NIL, '0);
    send_item(OP_PUT,    key_of(KIND_INT, '0), 3'd1, 64'h0123_4567_89ab_cdef);
    send_item(OP_LOOKUP, key_of(KIND_INT, '0), VAL_NIL, '0);
    send_item(OP_LOOKUP, key_of(KIND_BID, 64'hdead_beef_0bad_f00d), VAL_NIL, '0);
    // same word under another kind walks the same slots
    send_item(OP_TAKE,   key_of(KIND_TAB, '0), VAL_NIL, '0);
    // same low half gives the same hash
    send_item(OP_PUT,    key_of(KIND_INT, 64'hffff_ffff_0000_0000), 3'd4,
              64'h5555_aaaa_5555_aaaa);
    send_item(OP_LOOKUP, key_of(KIND_INT, 64'hffff_ffff_0000_0000), VAL_NIL, '0);
    send_item(OP_LOOKUP, key_of(KIND_TAB, '0), VAL_NIL, '0);
    send_item(OP_NONE,   key_of(KIND_SPARE7, '1), '1, '1);
    send_item(OP_NONE,   key_of(KIND_INT, '0), VAL_NIL, '0);
    for (int k = KIND_NUM; k <= KIND_BID; k++)
      send_item(OP_PUT, key_of(key_kind_t'(k), 64'h7fff_ffff_ffff_ffff), 3'd2,
                64'haaaa_5555_aaaa_5555);
    send_item(OP_LOOKUP, key_of(KIND_CLS, 64'h7fff_ffff_ffff_ffff), VAL_NIL, '0);
    wait_drained();
  endtask

  task automatic test_random_mix(int pct, int count);
    gap_pct = pct;
    repeat (count) send_random_item();
    wait_drained();
  endtask

  // fill every slot, then walk a full table for absent and present keys;
  // with slots and store entries equal in number both run out together
  task automatic test_probe_wrap();
    gap_pct = 8;
    while (tbl_count < STORE_DEPTH)
      send_item(OP_TAKE, key_of(key_kind_t'($urandom_range(7)), {$urandom, $urandom}),
                VAL_NIL, '0);
    gap_pct = 0;
    send_item(OP_PUT,    key_of(KIND_NUM, {$urandom, $urandom}), 3'd3, {$urandom, $urandom});
    send_item(OP_LOOKUP, key_of(KIND_SYS, {$urandom, $urandom}), VAL_NIL, '0);
    send_item(OP_TAKE,   key_of(KIND_BID, {$urandom, $urandom}), VAL_NIL, '0);
    repeat (6)
      send_item($urandom_range(1) ? OP_PUT : OP_LOOKUP,
                key_pool[$urandom_range(key_pool.size() - 1)], VTYPE_W'($urandom_range(7)),
                {$urandom, $urandom});
    send_item(OP_TAKE, key_pool[$urandom_range(key_pool.size() - 1)], VAL_NIL, '0);
    send_item(OP_NONE, key_of(KIND_INT, {$urandom, $urandom}), '1, '1);
    wait_drained();
  endtask

  // compare every result strobe with the oldest pending answer
  always @(posedge clk) begin
    table_answer_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", WORD_W'(out_entry_index), '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_valid !== 1'b1)
          report_mismatch("valid", WORD_W'(out_valid), WORD_W'(1'b1));
        if (out_hit !== want.hit)
          report_mismatch("hit", WORD_W'(out_hit), WORD_W'(want.hit));
        if (out_result_type !== want.rtype)
          report_mismatch("result_type", WORD_W'(out_result_type), WORD_W'(want.rtype));
        if (out_result_word !== want.rword)
          report_mismatch("result_word", out_result_word, want.rword);
        if (out_entry_index !== want.index)
          report_mismatch("entry_index", WORD_W'(out_entry_index), WORD_W'(want.index));
        if (out_status !== want.full)
          report_mismatch("status", WORD_W'(out_status), WORD_W'(want.full));
      end
    end
  end

  // watchdog on cycles with no item taken and no result
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_mix(0, 40);
    test_random_mix(55, 40);
    test_random_mix(8, 40);
    test_probe_wrap();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
